/* sv/assert_macros.svh */
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SERQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SERQ_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SERQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define SERQ_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

/* sv/serq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package serq_pkg;

  localparam int DEPTH     = 64;
  localparam int TAG_WIDTH = 16;
  localparam int POS_W     = 32;
  localparam int ADDR_W    = 6;
  localparam int CNT_W     = 7;
  localparam int PEEK_W    = 6;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_GET    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SHIFT,
    ST_PLACE,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_PEEK,
    RD_PREV,
    RD_PREV2
  } rd_sel_t;

  typedef struct packed {
    logic [POS_W-1:0]     pos;
    logic [TAG_WIDTH-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic    load_in;
    logic    latch_ok;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_new;
    logic    dec_idx;
    logic    resp_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic ok;
    logic fill_zero;
    logic idx_one;
    logic shift_stop;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* sv/serq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module serq_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  serq_pkg::status_t status,
  output serq_pkg::cmd_t   cmd
);
  import serq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (status.op == OP_INSERT && status.ok && !status.fill_zero) begin
          state_nxt = ST_SHIFT;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_SHIFT: begin
        priority if (status.shift_stop) begin
          state_nxt = ST_RESP;
        end else if (status.idx_one) begin
          state_nxt = ST_PLACE;
        end else begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_PLACE: state_nxt = ST_RESP;
      ST_RESP: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.rd_sel = RD_HEAD;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_DISPATCH: begin
        cmd.latch_ok = 1'b1;
        unique case (status.op)
          OP_INSERT: begin
            if (status.ok && !status.fill_zero) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_PREV;
            end else if (status.ok) begin
              cmd.wr_en  = 1'b1;
              cmd.wr_new = 1'b1;
            end
          end
          OP_GET: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_HEAD;
          end
          OP_PEEK: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_PEEK;
          end
          OP_CLEAR: begin
            cmd.rd_en = 1'b0;
          end
          default: cmd.rd_en = 1'b0;
        endcase
      end
      ST_SHIFT: begin
        cmd.wr_en = 1'b1;
        if (status.shift_stop) begin
          cmd.wr_new = 1'b1;
        end else begin
          cmd.dec_idx = 1'b1;
          if (!status.idx_one) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_PREV2;
          end
        end
      end
      ST_PLACE: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_new = 1'b1;
      end
      ST_RESP: begin
        cmd.resp_load = status.out_free;
      end
      default: in_ready = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

/* sv/serq_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module serq_dp (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire  [1:0]                         in_opcode,
  input  wire  [serq_pkg::POS_W-1:0]         in_insert_position,
  input  wire  [serq_pkg::TAG_WIDTH-1:0]     in_event_tag,
  input  wire  [serq_pkg::PEEK_W-1:0]        in_peek_index,
  input  wire                                cfg_we,
  input  wire  [serq_pkg::CNT_W-1:0]         cfg_capacity,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic                               out_success,
  output logic [serq_pkg::POS_W-1:0]         out_position,
  output logic [serq_pkg::TAG_WIDTH-1:0]     out_tag,
  output logic [serq_pkg::CNT_W-1:0]         out_occupancy,
  input  serq_pkg::cmd_t                     cmd,
  output serq_pkg::status_t                  status
);
  import serq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  op_t                  op_r;
  logic [POS_W-1:0]     pos_r;
  logic [TAG_WIDTH-1:0] tag_r;
  logic [PEEK_W-1:0]    peek_r;
  logic [CNT_W-1:0]     idx_r;
  logic                 ok_r;
  logic [ADDR_W-1:0]    head_r;
  logic [CNT_W-1:0]     fill_r;
  logic [CNT_W-1:0]     ring_r;
  logic                 out_valid_r;
  logic                 out_success_r;
  logic [POS_W-1:0]     out_position_r;
  logic [TAG_WIDTH-1:0] out_tag_r;
  logic [CNT_W-1:0]     out_occupancy_r;

  logic [ADDR_W-1:0]    head_nxt;
  logic [CNT_W-1:0]     fill_nxt;
  logic [CNT_W-1:0]     ring_nxt;
  logic [CNT_W-1:0]     rd_off;
  logic [ADDR_W-1:0]    rd_addr;
  logic [ADDR_W-1:0]    wr_addr;
  entry_t               wr_data;
  logic                 ok;
  logic                 returns_data;

  // ring slot of the entry off places behind the head
  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                input logic [CNT_W-1:0] off,
                                                input logic [CNT_W-1:0] ring);
    logic [CNT_W:0] sum;
    sum = {2'b00, head} + {1'b0, off};
    if (sum >= {1'b0, ring}) sum = sum - {1'b0, ring};
    return sum[ADDR_W-1:0];
  endfunction

  always_comb begin
    unique case (cmd.rd_sel)
      RD_HEAD:  rd_off = '0;
      RD_PEEK:  rd_off = {1'b0, peek_r};
      RD_PREV:  rd_off = idx_r - CNT_W'(1);
      RD_PREV2: rd_off = idx_r - CNT_W'(2);
      default:  rd_off = '0;
    endcase
  end

  assign rd_addr = slot_of(head_r, rd_off, ring_r);
  assign wr_addr = slot_of(head_r, idx_r, ring_r);
  assign wr_data = cmd.wr_new ? entry_t'{pos: pos_r, tag: tag_r} : rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    unique case (op_r)
      OP_INSERT: ok = (fill_r < ring_r);
      OP_GET:    ok = (fill_r != '0);
      OP_PEEK:   ok = ({1'b0, peek_r} < fill_r);
      OP_CLEAR:  ok = 1'b1;
      default:   ok = 1'b0;
    endcase
  end

  assign status.op         = op_r;
  assign status.ok         = ok;
  assign status.fill_zero  = (fill_r == '0);
  assign status.idx_one    = (idx_r == CNT_W'(1));
  assign status.shift_stop = (rd_data_r.pos <= pos_r);
  assign status.out_free   = !out_valid_r || out_ready;

  always_comb begin
    if (cfg_capacity == '0) begin
      ring_nxt = CNT_W'(1);
    end else if (cfg_capacity > CNT_W'(DEPTH)) begin
      ring_nxt = CNT_W'(DEPTH);
    end else begin
      ring_nxt = cfg_capacity;
    end
  end

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (ok_r) begin
      unique case (op_r)
        OP_INSERT: fill_nxt = fill_r + CNT_W'(1);
        OP_GET: begin
          fill_nxt = fill_r - CNT_W'(1);
          if ({1'b0, head_r} + CNT_W'(1) == ring_r) begin
            head_nxt = '0;
          end else begin
            head_nxt = head_r + ADDR_W'(1);
          end
        end
        OP_PEEK:  fill_nxt = fill_r;
        OP_CLEAR: begin
          head_nxt = '0;
          fill_nxt = '0;
        end
        default: fill_nxt = fill_r;
      endcase
    end
  end

  assign returns_data = ok_r && (op_r == OP_GET || op_r == OP_PEEK);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= op_t'(in_opcode);
      pos_r  <= in_insert_position;
      tag_r  <= in_event_tag;
      peek_r <= in_peek_index;
      idx_r  <= fill_r;
    end else if (cmd.dec_idx) begin
      idx_r <= idx_r - CNT_W'(1);
    end
    if (cmd.latch_ok) ok_r <= ok;
    if (cmd.resp_load) begin
      out_success_r   <= ok_r;
      out_position_r  <= returns_data ? rd_data_r.pos : '0;
      out_tag_r       <= returns_data ? rd_data_r.tag : '0;
      out_occupancy_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_r      <= CNT_W'(DEPTH);
      head_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        ring_r <= ring_nxt;
        head_r <= '0;
        fill_r <= '0;
      end else if (cmd.resp_load) begin
        head_r <= head_nxt;
        fill_r <= fill_nxt;
      end
      if (cmd.resp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_success   = out_success_r;
  assign out_position  = out_position_r;
  assign out_tag       = out_tag_r;
  assign out_occupancy = out_occupancy_r;

endmodule
`default_nettype wire

/* sv/sorted_event_ring_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Sorted event queue of up to 64 (position, tag) entries kept in ascending position order
// in a ring of single-port-write, registered-read memory; equal positions keep arrival
// order. One item is handled at a time. Get, peek, clear, a failed insert and an insert
// into an empty queue pass from acceptance through the dispatch state to the response
// state, where the result is registered. Any other insert runs a shift loop between them
// that moves one entry per cycle through the memory port, moving each entry with a later
// position back before the new one is placed. A result waits in an output register while
// the next item is taken; a result still waiting when the next one is ready holds the
// block until it leaves. Writing capacity (clamped to 1..64) empties the queue and may be
// done only while the block is idle.
module sorted_event_ring_queue (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [1:0]                     in_opcode,
  input  wire  [serq_pkg::POS_W-1:0]     in_insert_position,
  input  wire  [serq_pkg::TAG_WIDTH-1:0] in_event_tag,
  input  wire  [serq_pkg::PEEK_W-1:0]    in_peek_index,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic                           out_success,
  output logic [serq_pkg::POS_W-1:0]     out_position,
  output logic [serq_pkg::TAG_WIDTH-1:0] out_tag,
  output logic [serq_pkg::CNT_W-1:0]     out_occupancy,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [serq_pkg::CNT_W-1:0]     cfg_capacity
);
  import serq_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  serq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  serq_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_opcode          (in_opcode),
    .in_insert_position (in_insert_position),
    .in_event_tag       (in_event_tag),
    .in_peek_index      (in_peek_index),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_capacity       (cfg_capacity),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_success        (out_success),
    .out_position       (out_position),
    .out_tag            (out_tag),
    .out_occupancy      (out_occupancy),
    .cmd                (cmd),
    .status             (status)
  );

  `SERQ_ASSERT(a_occ_bound, clk, rst_n, out_valid |-> out_occupancy <= CNT_W'(DEPTH), "occupancy above depth")
  `SERQ_ASSERT(a_fail_zero, clk, rst_n, out_valid && !out_success |-> out_position == '0 && out_tag == '0, "failed item carries data")
  `SERQ_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready, "item taken while busy")
  `SERQ_ASSERT(a_write_busy, clk, rst_n, cmd.wr_en |-> !in_ready, "memory written while idle")
  `SERQ_ASSERT_RST(a_reset_out, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule
`default_nettype wire
